FILE: rtl/core/gpd_pkg.sv
package gpd_pkg;

  // default counter width for pixels produced per image
  localparam int COUNT_WIDTH = 24;

  // width of the pixel total register
  localparam int TOTAL_WIDTH = 24;

  // default queue depths (powers of two)
  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;

  // scaling constant for the value code
  localparam logic [31:0] SCALE_MUL = 32'h028C_CCCD;

  // pixel value of the short code made of two ones
  localparam logic [7:0] CODE_ONE_VALUE = 8'hFF;

  // input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // code phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  // number of value bits after the value prefix
  localparam logic [2:0] VALUE_BITS = 3'd7;

  // request from the input side
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  // one decoded pixel
  typedef struct packed {
    logic [7:0] pixel;
    logic       run_last;
    logic       image_done;
  } pix_item_t;

  // gray level for a 7-bit value code
  function automatic logic [7:0] scale_value(input logic [6:0] n);
    logic [31:0] prod;
    prod = ({25'd0, n} + 32'd1) * SCALE_MUL;
    if (n == 7'd0) begin
      return 8'd0;
    end
    return prod[31:24];
  endfunction

endpackage

FILE: rtl/core/gpd_fifo.sv
module gpd_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/core/gpd_bit_decoder.sv
module gpd_bit_decoder #(
  parameter int COUNT_WIDTH = gpd_pkg::COUNT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [gpd_pkg::TOTAL_WIDTH-1:0]     pixel_total_i,
  input  logic                                in_valid_i,
  input  gpd_pkg::in_item_t                   in_item_i,
  output logic                                in_pop_o,
  input  logic                                out_full_i,
  output logic                                out_push_o,
  output gpd_pkg::pix_item_t                  out_item_o
);

  localparam int LW = (COUNT_WIDTH > gpd_pkg::TOTAL_WIDTH) ? COUNT_WIDTH
                                                             : gpd_pkg::TOTAL_WIDTH;

  logic [1:0]             phase_q, phase_d;
  logic [6:0]             value_q, value_d;
  logic [2:0]             left_q, left_d;
  logic [2:0]             idx_q, idx_d;
  logic [COUNT_WIDTH-1:0] done_q, done_d;

  logic [LW-1:0] total_ext, cmax, limit, done_ext, next_ext;
  logic [COUNT_WIDTH-1:0] done_inc;
  logic       at_limit, hit_limit, cur_bit, emit, more_ahead, byte_end;
  logic [7:0] pix;
  logic [1:0] ph_n;
  logic [6:0] val_n;
  logic [2:0] left_n;
  logic [2:0] idx_m1, idx_m2;

  // effective pixel limit, clipped to the counter range
  assign total_ext = LW'(pixel_total_i);
  assign cmax      = LW'({COUNT_WIDTH{1'b1}});
  assign limit     = (total_ext < cmax) ? total_ext : cmax;
  assign done_ext  = LW'(done_q);
  assign done_inc  = done_q + COUNT_WIDTH'(1);
  assign next_ext  = LW'(done_inc);
  assign at_limit  = (done_ext >= limit);
  assign hit_limit = (next_ext == limit);

  assign cur_bit = in_item_i.data_byte[idx_q];

  // one code bit per cycle, except while a pixel waits on a full result queue
  always_comb begin
    emit   = 1'b0;
    pix    = 8'd0;
    ph_n   = gpd_pkg::PH_IDLE;
    val_n  = value_q;
    left_n = left_q;
    unique case (phase_q)
      gpd_pkg::PH_ONE: begin
        if (cur_bit) begin
          emit = 1'b1;
          pix  = gpd_pkg::CODE_ONE_VALUE;
        end else begin
          ph_n   = gpd_pkg::PH_VALUE;
          val_n  = 7'd0;
          left_n = gpd_pkg::VALUE_BITS;
        end
      end
      gpd_pkg::PH_VALUE: begin
        val_n  = {value_q[5:0], cur_bit};
        left_n = left_q - 3'd1;
        if (left_n == 3'd0) begin
          emit = 1'b1;
          pix  = gpd_pkg::scale_value(val_n);
        end else begin
          ph_n = gpd_pkg::PH_VALUE;
        end
      end
      default: begin
        if (cur_bit) begin
          ph_n = gpd_pkg::PH_ONE;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
  end

  // after a pixel the phase is idle: a later pixel comes from this byte
  // when the next bit is zero or the next two bits are both ones
  assign idx_m1 = idx_q - 3'd1;
  assign idx_m2 = idx_q - 3'd2;
  assign more_ahead = ((idx_q != 3'd0) && !in_item_i.data_byte[idx_m1]) ||
                      ((idx_q >= 3'd2) && in_item_i.data_byte[idx_m1] &&
                       in_item_i.data_byte[idx_m2]);

  assign byte_end = (idx_q == 3'd0) || (emit && hit_limit);

  assign out_item_o.pixel      = pix;
  assign out_item_o.image_done = hit_limit;
  assign out_item_o.run_last   = hit_limit || !more_ahead;

  // sequencing of the queue head
  always_comb begin
    phase_d    = phase_q;
    value_d    = value_q;
    left_d     = left_q;
    idx_d      = idx_q;
    done_d     = done_q;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    if (in_valid_i) begin
      if (in_item_i.kind == gpd_pkg::KIND_START) begin
        phase_d  = gpd_pkg::PH_IDLE;
        value_d  = 7'd0;
        left_d   = 3'd0;
        done_d   = '0;
        idx_d    = 3'd7;
        in_pop_o = 1'b1;
      end else if (at_limit) begin
        idx_d    = 3'd7;
        in_pop_o = 1'b1;
      end else if (!(emit && out_full_i)) begin
        phase_d    = ph_n;
        value_d    = val_n;
        left_d     = left_n;
        out_push_o = emit;
        if (emit) begin
          done_d = done_inc;
        end
        if (byte_end) begin
          idx_d    = 3'd7;
          in_pop_o = 1'b1;
        end else begin
          idx_d = idx_q - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gpd_pkg::PH_IDLE;
      value_q <= 7'd0;
      left_q  <= 3'd0;
      idx_q   <= 3'd7;
      done_q  <= '0;
    end else begin
      phase_q <= phase_d;
      value_q <= value_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  // no pixel goes into a full result queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("pixel pushed into full result queue");

  // the head is released only when there is one
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop_o |-> in_valid_i)
    else $error("input released while queue empty");

  // a start request clears the pixel count
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_pop_o && in_item_i.kind == gpd_pkg::KIND_START) |=> (done_q == '0))
    else $error("start request did not clear the count");

  // the pixel completing the canvas ends its byte
  a_done_ends_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && out_item_o.image_done) |-> (in_pop_o && out_item_o.run_last))
    else $error("canvas completed without closing the byte");

  // a new byte always starts at its top bit
  a_idx_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop_o |=> (idx_q == 3'd7))
    else $error("bit index not reloaded after byte");

endmodule

FILE: rtl/core/gray_pixel_prefix_code_decoder_top.sv
// order: a pixel enters the result queue as its last code bit is read; an idle
//   block reads the top bit of a new byte right after acceptance
// throughput: one code bit per cycle, except while a pixel waits on a full
//   result queue; the bits left in a data byte are skipped once the canvas
//   completes inside it; start bytes and bytes past a full canvas are released unread
// reset: asynchronous, active low; empties both queues, clears phase, count, total
module gray_pixel_prefix_code_decoder_top #(
  parameter int COUNT_WIDTH = gpd_pkg::COUNT_WIDTH,
  parameter int IN_DEPTH    = gpd_pkg::IN_DEPTH,
  parameter int OUT_DEPTH   = gpd_pkg::OUT_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gpd_pkg::TOTAL_WIDTH-1:0] cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic                            kind_i,
  input  logic [7:0]                      data_byte_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      pixel_o,
  output logic                            run_last_o,
  output logic                            image_done_o
);

  localparam int IN_W  = $bits(gpd_pkg::in_item_t);
  localparam int OUT_W = $bits(gpd_pkg::pix_item_t);

  logic [gpd_pkg::TOTAL_WIDTH-1:0] pixel_total_q;
  gpd_pkg::in_item_t  in_wr, in_head;
  gpd_pkg::pix_item_t out_wr, out_head;
  logic               in_empty, in_pop, out_full, out_push;

  // pixel total register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_total_q <= '0;
    end else if (cfg_we_i) begin
      pixel_total_q <= cfg_wdata_i;
    end
  end

  assign in_wr.kind      = kind_i;
  assign in_wr.data_byte = data_byte_i;

  // input request queue
  gpd_fifo #(
    .WIDTH (IN_W),
    .DEPTH (IN_DEPTH)
  ) u_in_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_wr),
    .full_o  (full),
    .pop_i   (in_pop),
    .empty_o (in_empty),
    .rdata_o (in_head)
  );

  // bit serial code walker
  gpd_bit_decoder #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_total_i (pixel_total_q),
    .in_valid_i    (!in_empty),
    .in_item_i     (in_head),
    .in_pop_o      (in_pop),
    .out_full_i    (out_full),
    .out_push_o    (out_push),
    .out_item_o    (out_wr)
  );

  // result queue
  gpd_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wr),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_head)
  );

  assign pixel_o      = out_head.pixel;
  assign run_last_o   = out_head.run_last;
  assign image_done_o = out_head.image_done;

endmodule
